@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising clk_i edge, skipped while rst_ni is low.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checked on every rising clk_i edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

@@ rtl/pdd_pkg.sv @@
`default_nettype none

package pdd_pkg;

  localparam int unsigned COORD_BITS    = 24;
  // floor(sqrt(dx^2 + dy^2)) with |dx|,|dy| < 2^COORD_BITS fits in COORD_BITS+1 bits
  localparam int unsigned LEN_BITS      = COORD_BITS + 1;
  localparam int unsigned CNT_BITS      = $clog2(LEN_BITS);
  localparam int unsigned SPACING_BITS  = 24;
  localparam logic [SPACING_BITS-1:0] SPACING_RESET = 24'd512;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         first_point;
    logic                         last_point;
  } pdd_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] out_x;
    logic signed [COORD_BITS-1:0] out_y;
    logic                         goal_mark;
    logic                         run_end;
  } pdd_out_t;

endpackage

`default_nettype wire

@@ rtl/path_distance_decimator.sv @@
`default_nettype none

// Path thinning by travelled distance. Points come in over the in_* channel,
// kept waypoints leave over out_*, both valid/ready; one point is worked on at a
// time. A first point is sent on as a waypoint (a one-point path gives nothing).
// Any other point runs through the bit-serial segment length unit: shift-add
// squaring, an add of the squares, a restoring square root and a registered
// done; the controller then updates the distance sum. A dropped point frees the
// input after that update; a kept point or the goal then waits in the emit state
// until the output register is free and is loaded into it; in_ready_o comes
// back once the results of that point are loaded. A point is kept when the sum,
// saturating at SUM_BITS, reaches spacing; a last point always goes out with
// goal_mark set, after its kept copy if it was kept, and run_end flags the last
// result of each input transfer.
// spacing (reset 2.0 m) must only be written while the block is idle.
module path_distance_decimator
  import pdd_pkg::*;
#(
  parameter int unsigned SUM_BITS = 28
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_we_i,
  input  logic [SPACING_BITS-1:0] cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  pdd_in_t                 in_data_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output pdd_out_t                out_data_o
);

`include "assert_macros.svh"

  localparam int unsigned AW   = ((SUM_BITS > LEN_BITS) ? SUM_BITS : LEN_BITS) + 1;
  localparam int unsigned CMPW = (SUM_BITS > SPACING_BITS) ? SUM_BITS : SPACING_BITS;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEG  = 2'd1;
  localparam logic [1:0] ST_ACC  = 2'd2;
  localparam logic [1:0] ST_EMIT = 2'd3;

  logic [1:0]              state_q, state_d;
  logic [SPACING_BITS-1:0] spacing_q, spacing_d;
  logic [SUM_BITS-1:0]     sum_q, sum_d;
  logic [COORD_BITS-1:0]   prev_x_q, prev_x_d, prev_y_q, prev_y_d;
  logic [COORD_BITS-1:0]   cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic                    last_q, last_d;
  logic                    pend_keep_q, pend_keep_d;
  logic                    pend_goal_q, pend_goal_d;
  logic                    out_valid_q, out_valid_d;
  pdd_out_t                out_q, out_d;

  logic                    in_xfer;
  logic                    slot_free;
  logic                    seg_start;
  logic                    seg_done;
  logic [LEN_BITS-1:0]     seg_len;
  logic [AW-1:0]           sum_tot;
  logic [SUM_BITS-1:0]     sum_sat;
  logic                    keep;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign seg_start  = in_xfer && !in_data_i.first_point;
  // output register frees up in the cycle its result is taken
  assign slot_free  = !out_valid_q || out_ready_i;

  pdd_seg_len u_seg_len (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (seg_start),
    .ax_i    (in_data_i.point_x),
    .ay_i    (in_data_i.point_y),
    .bx_i    (prev_x_q),
    .by_i    (prev_y_q),
    .done_o  (seg_done),
    .len_o   (seg_len)
  );

  // saturating accumulate and spacing compare
  assign sum_tot = AW'(sum_q) + AW'(seg_len);
  assign sum_sat = (|sum_tot[AW-1:SUM_BITS]) ? {SUM_BITS{1'b1}} : sum_tot[SUM_BITS-1:0];
  assign keep    = CMPW'(sum_sat) >= CMPW'(spacing_q);

  always_comb begin
    state_d     = state_q;
    spacing_d   = spacing_q;
    sum_d       = sum_q;
    prev_x_d    = prev_x_q;
    prev_y_d    = prev_y_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    last_d      = last_q;
    pend_keep_d = pend_keep_q;
    pend_goal_d = pend_goal_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cfg_we_i) begin
      spacing_d = cfg_data_i;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          // prev is only needed at this edge, so it moves on right away
          prev_x_d = in_data_i.point_x;
          prev_y_d = in_data_i.point_y;
          cur_x_d  = in_data_i.point_x;
          cur_y_d  = in_data_i.point_y;
          last_d   = in_data_i.last_point;
          if (in_data_i.first_point) begin
            sum_d       = '0;
            pend_keep_d = !in_data_i.last_point;
            pend_goal_d = 1'b0;
            state_d     = in_data_i.last_point ? ST_IDLE : ST_EMIT;
          end else begin
            state_d = ST_SEG;
          end
        end
      end
      ST_SEG: begin
        if (seg_done) begin
          state_d = ST_ACC;
        end
      end
      ST_ACC: begin
        sum_d       = keep ? '0 : sum_sat;
        pend_keep_d = keep;
        pend_goal_d = last_q;
        state_d     = (keep || last_q) ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d     = 1'b1;
          out_d.out_x     = cur_x_q;
          out_d.out_y     = cur_y_q;
          if (pend_keep_q) begin
            out_d.goal_mark = 1'b0;
            out_d.run_end   = !pend_goal_q;
            pend_keep_d     = 1'b0;
            if (!pend_goal_q) begin
              state_d = ST_IDLE;
            end
          end else begin
            out_d.goal_mark = 1'b1;
            out_d.run_end   = 1'b1;
            pend_goal_d     = 1'b0;
            state_d         = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      spacing_q   <= SPACING_RESET;
      sum_q       <= '0;
      prev_x_q    <= '0;
      prev_y_q    <= '0;
      pend_keep_q <= 1'b0;
      pend_goal_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      spacing_q   <= spacing_d;
      sum_q       <= sum_d;
      prev_x_q    <= prev_x_d;
      prev_y_q    <= prev_y_d;
      pend_keep_q <= pend_keep_d;
      pend_goal_q <= pend_goal_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q <= cur_x_d;
    cur_y_q <= cur_y_d;
    last_q  <= last_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // length unit only reports back while the controller waits for it
  `ASSERT_CLK(a_seg_done_in_seg, seg_done |-> (state_q == ST_SEG), "segment done outside SEG")
  // emission state always has something left to send
  `ASSERT_CLK(a_emit_pending, (state_q == ST_EMIT) |-> (pend_keep_q || pend_goal_q),
              "EMIT with nothing pending")
  // a result without run_end is always followed by the goal copy
  `ASSERT_CLK(a_goal_follows,
              (out_valid_o && out_ready_i && !out_data_o.run_end)
                |=> (out_valid_o && out_data_o.goal_mark),
              "goal result missing after kept point")

endmodule

`default_nettype wire

@@ rtl/pdd_seg_len.sv @@
`default_nettype none

// Segment length floor(sqrt(dx^2 + dy^2)), bit serial:
// shift-add squaring one multiplier bit per cycle, then a restoring
// square root one root bit per cycle.
module pdd_seg_len
  import pdd_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic signed [COORD_BITS-1:0] ax_i,
  input  logic signed [COORD_BITS-1:0] ay_i,
  input  logic signed [COORD_BITS-1:0] bx_i,
  input  logic signed [COORD_BITS-1:0] by_i,
  output logic                         done_o,
  output logic [LEN_BITS-1:0]          len_o
);

  localparam int unsigned PW = 2 * COORD_BITS;
  localparam int unsigned RW = 2 * LEN_BITS;

  localparam logic [1:0] P_IDLE = 2'd0;
  localparam logic [1:0] P_MUL  = 2'd1;
  localparam logic [1:0] P_ADD  = 2'd2;
  localparam logic [1:0] P_SQRT = 2'd3;

  logic [1:0]            phase_q, phase_d;
  logic [CNT_BITS-1:0]   cnt_q, cnt_d;
  logic                  done_q, done_d;
  logic [COORD_BITS-1:0] mx_q, mx_d, my_q, my_d;
  logic [PW-1:0]         px_q, px_d, py_q, py_d;
  logic [RW-1:0]         rad_q, rad_d;
  logic [LEN_BITS-1:0]   rem_q, rem_d;
  logic [LEN_BITS-1:0]   root_q, root_d;

  logic [COORD_BITS-1:0] dx, dy;
  logic [COORD_BITS:0]   hi_x, hi_y;
  logic [PW:0]           rad_sum;
  logic [LEN_BITS+1:0]   rem_sh, trial, rem_diff;
  logic                  fits;

  // magnitude of the coordinate difference; always below 2^COORD_BITS
  function automatic logic [COORD_BITS-1:0] abs_diff(
    input logic signed [COORD_BITS-1:0] a,
    input logic signed [COORD_BITS-1:0] b
  );
    logic [COORD_BITS:0] ab, ba;
    ab = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    ba = {b[COORD_BITS-1], b} - {a[COORD_BITS-1], a};
    return (a >= b) ? ab[COORD_BITS-1:0] : ba[COORD_BITS-1:0];
  endfunction

  assign dx = abs_diff(ax_i, bx_i);
  assign dy = abs_diff(ay_i, by_i);

  assign hi_x = {1'b0, px_q[PW-1:COORD_BITS]} + (px_q[0] ? {1'b0, mx_q} : '0);
  assign hi_y = {1'b0, py_q[PW-1:COORD_BITS]} + (py_q[0] ? {1'b0, my_q} : '0);

  assign rad_sum = {1'b0, px_q} + {1'b0, py_q};

  // two radicand bits in, one root bit out
  assign rem_sh   = {rem_q, rad_q[RW-1:RW-2]};
  assign trial    = {root_q, 2'b01};
  assign fits     = rem_sh >= trial;
  assign rem_diff = rem_sh - trial;

  always_comb begin
    phase_d = phase_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    mx_d    = mx_q;
    my_d    = my_q;
    px_d    = px_q;
    py_d    = py_q;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    unique case (phase_q)
      P_IDLE: begin
        if (start_i) begin
          mx_d    = dx;
          my_d    = dy;
          px_d    = {{COORD_BITS{1'b0}}, dx};
          py_d    = {{COORD_BITS{1'b0}}, dy};
          cnt_d   = CNT_BITS'(COORD_BITS - 1);
          phase_d = P_MUL;
        end
      end
      P_MUL: begin
        px_d = {hi_x, px_q[COORD_BITS-1:1]};
        py_d = {hi_y, py_q[COORD_BITS-1:1]};
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          phase_d = P_ADD;
        end
      end
      P_ADD: begin
        rad_d   = {{(RW-PW-1){1'b0}}, rad_sum};
        rem_d   = '0;
        root_d  = '0;
        cnt_d   = CNT_BITS'(LEN_BITS - 1);
        phase_d = P_SQRT;
      end
      P_SQRT: begin
        rem_d  = fits ? rem_diff[LEN_BITS-1:0] : rem_sh[LEN_BITS-1:0];
        root_d = {root_q[LEN_BITS-2:0], fits};
        rad_d  = {rad_q[RW-3:0], 2'b00};
        cnt_d  = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          phase_d = P_IDLE;
        end
      end
      default: phase_d = P_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mx_q   <= mx_d;
    my_q   <= my_d;
    px_q   <= px_d;
    py_q   <= py_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
  end

  assign done_o = done_q;
  assign len_o  = root_q;

endmodule

`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 100ps

// Testbench for path_distance_decimator.
// Path points go in over the in_* channel; a local model of the decimator
// predicts the kept waypoints, which are queued and compared field by field
// with every transfer on the out_* channel. The run goes through directed
// paths (reset spacing, coordinate extremes, zero and maximum spacing),
// then random paths under three idle patterns and several spacing values.
module tb
  import pdd_pkg::*;
();

  localparam int unsigned SUM_W = 28;
  localparam longint unsigned SUM_MAX = (64'd1 << SUM_W) - 1;
  // Longer than a full pass of the segment length unit, with margin.
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
  localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam logic [SPACING_BITS-1:0] SPACING_MAX = {SPACING_BITS{1'b1}};

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we_i = 1'b0;
  logic [SPACING_BITS-1:0] cfg_data_i = '0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  pdd_in_t                 in_data_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  pdd_out_t                out_data_o;

  path_distance_decimator #(
    .SUM_BITS(SUM_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always #10 clk_i = ~clk_i;

  // Shadow state of the decimator.
  logic [SPACING_BITS-1:0]      spacing_cfg = SPACING_RESET;
  logic signed [COORD_BITS-1:0] last_x = '0;
  logic signed [COORD_BITS-1:0] last_y = '0;
  logic [SUM_W-1:0]             travelled = '0;

  pdd_out_t pending_waypoints[$];

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned points_sent = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  // Watchdog.
  initial begin
    while (cycle_count < CYCLE_LIMIT) @(posedge clk_i);
    $display("tb: failure");
    $finish;
  end

  // Receiver stalls, redrawn every cycle.
  always @(negedge clk_i) begin
    out_ready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  // floor(sqrt(n)) bit by bit, n < 2^50 so the root fits in 25 bits.
  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 25; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  task automatic push_waypoint(logic signed [COORD_BITS-1:0] x,
                               logic signed [COORD_BITS-1:0] y, logic goal, logic tail);
    pdd_out_t w;
    w.out_x     = x;
    w.out_y     = y;
    w.goal_mark = goal;
    w.run_end   = tail;
    pending_waypoints = {pending_waypoints, w};
  endtask

  // Advance the shadow state by one accepted point and queue its waypoints.
  task automatic track_point(pdd_in_t p);
    longint          dx;
    longint          dy;
    longint unsigned total;
    logic            keep;
    dx = longint'(p.point_x) - longint'(last_x);
    dy = longint'(p.point_y) - longint'(last_y);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    if (p.first_point) begin
      last_x    = p.point_x;
      last_y    = p.point_y;
      travelled = '0;
      // a one-point path yields nothing
      if (!p.last_point) push_waypoint(p.point_x, p.point_y, 1'b0, 1'b1);
    end else begin
      total = longint'(travelled) + int_sqrt(longint'(dx * dx + dy * dy));
      if (total > SUM_MAX) total = SUM_MAX;
      travelled = total[SUM_W-1:0];
      keep = (travelled >= spacing_cfg);
      if (keep) begin
        travelled = '0;
        push_waypoint(p.point_x, p.point_y, 1'b0, !p.last_point);
      end
      // goal goes out again, even right after the spacing rule kept it
      if (p.last_point) push_waypoint(p.point_x, p.point_y, 1'b1, 1'b1);
      last_x = p.point_x;
      last_y = p.point_y;
    end
  endtask

  // Result checker: every output transfer against the oldest expectation.
  always @(posedge clk_i) begin : check_out
    pdd_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_waypoints.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected waypoint x=%0d y=%0d goal=%0b end=%0b",
                   out_data_o.out_x, out_data_o.out_y,
                   out_data_o.goal_mark, out_data_o.run_end);
        mismatch_count++;
      end else begin
        want = pending_waypoints.pop_front();
        if (out_data_o.out_x !== want.out_x || out_data_o.out_y !== want.out_y ||
            out_data_o.goal_mark !== want.goal_mark ||
            out_data_o.run_end !== want.run_end) begin
          if (mismatch_count < 10)
            $display("waypoint mismatch: exp x=%0d y=%0d goal=%0b end=%0b",
                     want.out_x, want.out_y, want.goal_mark, want.run_end,
                     ", got x=%0d y=%0d goal=%0b end=%0b",
                     out_data_o.out_x, out_data_o.out_y,
                     out_data_o.goal_mark, out_data_o.run_end);
          mismatch_count++;
        end
      end
    end
  end

  // One input transfer. Entered and left at a falling edge; valid stays high
  // afterwards so back-to-back points need no extra assignment.
  task automatic send_point(logic signed [COORD_BITS-1:0] x,
                            logic signed [COORD_BITS-1:0] y, logic first, logic last);
    pdd_in_t p;
    p.point_x     = x;
    p.point_y     = y;
    p.first_point = first;
    p.last_point  = last;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= p;
    do @(posedge clk_i); while (!in_ready_o);
    track_point(p);
    points_sent++;
    @(negedge clk_i);
  endtask

  // Wait for all waypoints, then let a dropped point finish in the block.
  task automatic drain;
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_waypoints.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_spacing(logic [SPACING_BITS-1:0] value);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    spacing_cfg  = value;
  endtask

  // Reset spacing of 2.0 m; points before any first point; goal handling.
  task automatic test_reset_spacing;
    send_point(24'sd300, 24'sd400, 1'b0, 1'b0);   // 500 from origin, dropped
    send_point(24'sd300, 24'sd412, 1'b0, 1'b0);   // sum reaches 512, kept
    send_point(24'sd0, 24'sd0, 1'b1, 1'b0);
    send_point(24'sd5, 24'sd5, 1'b1, 1'b1);       // one-point path
    send_point(24'sd5, 24'sd5, 1'b0, 1'b1);       // goal only
    send_point(24'sd5, 24'sd517, 1'b0, 1'b0);     // after a goal, same path
    send_point(24'sd5, 24'sd1100, 1'b0, 1'b1);    // kept and goal
  endtask

  task automatic test_extremes;
    send_point(C_MIN, C_MIN, 1'b1, 1'b0);
    send_point(C_MAX, C_MAX, 1'b0, 1'b0);
    send_point(C_MIN, C_MAX, 1'b0, 1'b1);
    send_point(C_MAX, C_MIN, 1'b1, 1'b0);
    send_point(C_MIN, C_MIN, 1'b0, 1'b0);
    send_point(-24'sd1, -24'sd1, 1'b0, 1'b1);
  endtask

  // Zero spacing keeps every point, zero-length segments included.
  task automatic test_zero_spacing;
    set_spacing('0);
    send_point(24'sd1, 24'sd1, 1'b1, 1'b0);
    send_point(24'sd1, 24'sd1, 1'b0, 1'b0);
    send_point(24'sd1, 24'sd1, 1'b0, 1'b1);
    send_point(-24'sd1, -24'sd1, 1'b0, 1'b0);
  endtask

  task automatic test_max_spacing;
    set_spacing(SPACING_MAX);
    send_point(24'sd0, 24'sd0, 1'b1, 1'b0);
    send_point(C_MAX, 24'sd0, 1'b0, 1'b0);
    send_point(C_MIN, 24'sd0, 1'b0, 1'b0);        // sum passes the maximum
    send_point(C_MIN, 24'sd1000, 1'b0, 1'b0);
    send_point(C_MIN, 24'sd2000, 1'b0, 1'b1);     // goal only
  endtask

  function automatic logic signed [COORD_BITS-1:0] nudge(logic signed [COORD_BITS-1:0] c,
                                                         int unsigned reach);
    int d;
    if ($urandom_range(0, 9) < 2) return COORD_BITS'($urandom);
    d = int'($urandom_range(0, 2 * reach)) - int'(reach);
    return c + COORD_BITS'(d);
  endfunction

  // Mostly well-formed paths with random steps sized to the spacing, some noise.
  task automatic test_random_paths(int unsigned count, logic [SPACING_BITS-1:0] value);
    int unsigned                  stop_at;
    int unsigned                  reach;
    int unsigned                  len;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    set_spacing(value);
    reach = value / 3 + 4;
    if (reach > (1 << 22)) reach = 1 << 22;
    stop_at = points_sent + count;
    while (points_sent < stop_at) begin
      if ($urandom_range(0, 99) < 85) begin
        len = $urandom_range(1, 12);
        x = COORD_BITS'($urandom);
        y = COORD_BITS'($urandom);
        send_point(x, y, 1'b1, len == 1);
        for (int unsigned k = 1; k < len; k++) begin
          x = nudge(x, reach);
          y = nudge(y, reach);
          send_point(x, y, 1'b0, k == len - 1);
        end
      end else begin
        send_point(COORD_BITS'($urandom), COORD_BITS'($urandom),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 18;
    rx_idle_pct = 71;
    test_reset_spacing();
    test_extremes();
    test_zero_spacing();
    test_max_spacing();
    test_random_paths(320, 24'($urandom_range(0, 2047)));
    test_random_paths(320, 24'($urandom));

    tx_idle_pct = 71;
    rx_idle_pct = 18;
    test_random_paths(320, 24'($urandom_range(0, 2047)));
    test_random_paths(320, 24'($urandom));

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_paths(320, 24'($urandom_range(0, 2047)));
    test_random_paths(320, 24'($urandom));

    drain();
    if (mismatch_count == 0 && pending_waypoints.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
